[src/annex_b_nal_start_code_splitter_unit_assert.svh]
// assertion macros for the start code splitter
`ifndef ANNEX_B_NAL_START_CODE_SPLITTER_UNIT_ASSERT_SVH
`define ANNEX_B_NAL_START_CODE_SPLITTER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ANBSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("anbsc assertion failed");

// next-cycle implication, checked outside reset
`define ANBSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("anbsc assertion failed");

`endif

[src/anbsc_pkg.sv]
`default_nettype none

package anbsc_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

    localparam logic [7:0] ZeroByte = 8'h00;
    localparam logic [7:0] OneByte  = 8'h01;

    localparam logic [2:0] PfxNone  = 3'd0;
    localparam logic [2:0] PfxShort = 3'd3;
    localparam logic [2:0] PfxLong  = 3'd4;

    typedef logic [3:0][7:0] window_t;

    // one scan job: bytes held plus the new byte, byte count 1..4
    typedef struct packed {
        window_t    win;
        logic [2:0] count;
        logic       eop;
    } job_t;

    function automatic logic [2:0] test_prefix(input window_t w, input logic [2:0] avail);
        logic [2:0] pfx;
        pfx = PfxNone;
        if (avail >= 3'd4 && w[0] == ZeroByte && w[1] == ZeroByte &&
            w[2] == ZeroByte && w[3] == OneByte) begin
            pfx = PfxLong;
        end else if (avail >= 3'd3 && w[0] == ZeroByte && w[1] == ZeroByte &&
                     w[2] == OneByte) begin
            pfx = PfxShort;
        end
        return pfx;
    endfunction

endpackage

`default_nettype wire

[src/anbsc_queue.sv]
`default_nettype none

module anbsc_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire anbsc_pkg::job_t  push_job,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output anbsc_pkg::job_t       head_job
);

    anbsc_pkg::job_t                    mem_reg [anbsc_pkg::QueueDepth];
    logic [anbsc_pkg::QPtrW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [anbsc_pkg::QPtrW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [anbsc_pkg::QCntW-1:0]        count_reg, count_next;

    localparam logic [anbsc_pkg::QPtrW-1:0] LastPtr =
        anbsc_pkg::QPtrW'(anbsc_pkg::QueueDepth - 1);
    localparam logic [anbsc_pkg::QCntW-1:0] FullCnt =
        anbsc_pkg::QCntW'(anbsc_pkg::QueueDepth);

    assign full       = (count_reg == FullCnt);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[src/anbsc_front.sv]
`default_nettype none

module anbsc_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_byte_in,
    input  wire logic             s_end_of_packet,
    input  wire logic             q_full,
    output logic                  push,
    output anbsc_pkg::job_t       push_job
);

    logic [7:0] look_reg [3];
    logic [1:0] held_reg, held_next;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // window: held bytes first, then the new byte
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            push_job.win[k] = (2'(k) < held_reg) ? look_reg[k] : s_byte_in;
        end
        push_job.win[3] = s_byte_in;
        push_job.count  = {1'b0, held_reg} + 3'd1;
        push_job.eop    = s_end_of_packet;
    end

    assign push = accept && (s_end_of_packet || held_reg == 2'd3);

    always_comb begin
        held_next = held_reg;
        if (accept) begin
            if (s_end_of_packet) begin
                held_next = 2'd0;
            end else if (held_reg != 2'd3) begin
                held_next = held_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 2'd0;
        end else begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !s_end_of_packet) begin
            if (held_reg == 2'd3) begin
                look_reg[0] <= look_reg[1];
                look_reg[1] <= look_reg[2];
                look_reg[2] <= s_byte_in;
            end else begin
                look_reg[held_reg] <= s_byte_in;
            end
        end
    end

endmodule

`default_nettype wire

[src/anbsc_back.sv]
`default_nettype none

module anbsc_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    input  wire anbsc_pkg::job_t  q_job,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_byte_out,
    output logic                  m_nal_start,
    output logic [2:0]            m_prefix_length,
    output logic                  m_packet_end,
    output logic                  m_packet_bad,
    output logic                  m_run_last
);

    logic [1:0] idx_reg, idx_next;
    logic [1:0] skip_reg, skip_next;
    logic       head_reg, head_next;
    logic       bad_reg, bad_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg;
    logic       m_nal_reg;
    logic [2:0] m_pfx_reg;
    logic       m_end_reg;
    logic       m_bad_reg;
    logic       m_last_reg;

    anbsc_pkg::window_t sw;
    logic [2:0] pos [4];
    logic [2:0] avail;
    logic [2:0] pfx_found;
    logic [2:0] pfx;
    logic [1:0] last_idx;
    logic       is_last;
    logic       load;
    logic       step_bad;

    assign load = q_valid && (!m_valid_reg || m_ready);

    // window shifted to the current scan position
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pos[k] = {1'b0, idx_reg} + 3'(k);
            sw[k]  = (pos[k] <= 3'd3) ? q_job.win[pos[k][1:0]] : anbsc_pkg::ZeroByte;
        end
    end

    assign avail     = q_job.count - {1'b0, idx_reg};
    assign pfx_found = anbsc_pkg::test_prefix(sw, avail);
    assign last_idx  = q_job.eop ? 2'(q_job.count - 3'd1) : 2'd0;
    assign is_last   = (idx_reg == last_idx);
    assign pop       = load && is_last;

    always_comb begin
        pfx       = anbsc_pkg::PfxNone;
        skip_next = skip_reg;
        head_next = head_reg;
        step_bad  = bad_reg;
        if (skip_reg != 2'd0) begin
            skip_next = skip_reg - 2'd1;
        end else if (avail >= 3'd3) begin
            pfx = pfx_found;
            if (pfx_found != anbsc_pkg::PfxNone) begin
                skip_next = 2'(pfx_found - 3'd1);
            end
        end
        if (head_reg) begin
            if (pfx == anbsc_pkg::PfxNone) begin
                step_bad = 1'b1;
            end
            head_next = 1'b0;
        end
        if (step_bad) begin
            pfx = anbsc_pkg::PfxNone;
        end
        bad_next = step_bad;
        idx_next = idx_reg + 2'd1;
        if (is_last) begin
            idx_next = 2'd0;
            if (q_job.eop) begin
                skip_next = 2'd0;
                head_next = 1'b1;
                bad_next  = 1'b0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            skip_reg    <= 2'd0;
            head_reg    <= 1'b1;
            bad_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (load) begin
                idx_reg  <= idx_next;
                skip_reg <= skip_next;
                head_reg <= head_next;
                bad_reg  <= bad_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_byte_reg <= sw[0];
            m_nal_reg  <= (pfx != anbsc_pkg::PfxNone);
            m_pfx_reg  <= pfx;
            m_end_reg  <= q_job.eop && is_last;
            m_bad_reg  <= step_bad;
            m_last_reg <= is_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_byte_out      = m_byte_reg;
    assign m_nal_start     = m_nal_reg;
    assign m_prefix_length = m_pfx_reg;
    assign m_packet_end    = m_end_reg;
    assign m_packet_bad    = m_bad_reg;
    assign m_run_last      = m_last_reg;

endmodule

`default_nettype wire

[src/annex_b_nal_start_code_splitter_unit.sv]
// Annex B start code splitter: bytes in on the s_ channel (byte plus end of
// packet mark), the same bytes out in order on the m_ channel, each tagged
// with NAL start, prefix length (3 or 4), packet end, packet bad and run last.
// A byte is held until three more bytes have arrived or the packet ends, so a
// result trails its input byte by three bytes; the end-of-packet byte flushes
// up to four results, one per cycle while the receiver is ready, the last of
// them marked run last. Throughput is one byte per cycle while the packet
// streams and the receiver is ready; a packet end adds up to three results,
// absorbed by a two-entry job queue between the front (byte holding) and the
// back (scanning) stages. Jobs pass the queue, then the result register.
// Reset clears the held bytes, the queue and the scan state, and the next byte
// is taken as the head of a packet. When the receiver stalls the result
// register holds; the queue fills and s_ready drops only once it is full.
`default_nettype none

module annex_b_nal_start_code_splitter_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_byte_in,
    input  wire logic       s_end_of_packet,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_byte_out,
    output logic            m_nal_start,
    output logic [2:0]      m_prefix_length,
    output logic            m_packet_end,
    output logic            m_packet_bad,
    output logic            m_run_last
);

    logic            q_full;
    logic            q_push;
    anbsc_pkg::job_t q_push_job;
    logic            q_pop;
    logic            q_valid;
    anbsc_pkg::job_t q_head_job;

    anbsc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .s_end_of_packet (s_end_of_packet),
        .q_full          (q_full),
        .push            (q_push),
        .push_job        (q_push_job)
    );

    anbsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head_job)
    );

    anbsc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_job           (q_head_job),
        .pop             (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_out      (m_byte_out),
        .m_nal_start     (m_nal_start),
        .m_prefix_length (m_prefix_length),
        .m_packet_end    (m_packet_end),
        .m_packet_bad    (m_packet_bad),
        .m_run_last      (m_run_last)
    );

endmodule

`default_nettype wire

[src/anbsc_checker.sv]
`default_nettype none

`include "annex_b_nal_start_code_splitter_unit_assert.svh"

module anbsc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_byte_out,
    input wire logic       m_nal_start,
    input wire logic [2:0] m_prefix_length,
    input wire logic       m_packet_end,
    input wire logic       m_packet_bad,
    input wire logic       m_run_last
);

    `ANBSC_ASSERT_NOW(a_nal_not_bad, m_valid && m_nal_start, !m_packet_bad)
    `ANBSC_ASSERT_NOW(a_nal_len, m_valid && m_nal_start, m_prefix_length - 3'd3 <= 3'd1)
    `ANBSC_ASSERT_NOW(a_no_nal_no_len, m_valid && !m_nal_start, m_prefix_length == 3'd0)
    `ANBSC_ASSERT_NOW(a_end_is_run_last, m_valid && m_packet_end, m_run_last)
    `ANBSC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_byte_out))

endmodule

bind annex_b_nal_start_code_splitter_unit anbsc_checker u_anbsc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_byte_out      (m_byte_out),
    .m_nal_start     (m_nal_start),
    .m_prefix_length (m_prefix_length),
    .m_packet_end    (m_packet_end),
    .m_packet_bad    (m_packet_bad),
    .m_run_last      (m_run_last)
);

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       nal;
        logic [2:0] plen;
        logic       pend;
        logic       bad;
        logic       last;
    } marked_byte_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         eop;
        logic         typed;
        marked_byte_t want;
    } stim_row_t;

    localparam int unsigned DirectedRows = 25;
    localparam int unsigned RandomBytes  = 300;

    // directed part: one-byte and two-byte packets, both prefix lengths, a prefix
    // right at the packet end, a packet with no leading start code
    localparam stim_row_t DIRECTED [DirectedRows] = '{
        '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b0, anbsc_pkg::PfxNone, 1'b1, 1'b1, 1'b1}},
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, anbsc_pkg::PfxNone, 1'b1, 1'b1, 1'b1}},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h65, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b1, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b1, 1'b0, '0}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte_in = 8'h00;
    logic       s_end_of_packet = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_byte_out;
    logic       m_nal_start;
    logic [2:0] m_prefix_length;
    logic       m_packet_end;
    logic       m_packet_bad;
    logic       m_run_last;

    annex_b_nal_start_code_splitter_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .s_end_of_packet (s_end_of_packet),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_out      (m_byte_out),
        .m_nal_start     (m_nal_start),
        .m_prefix_length (m_prefix_length),
        .m_packet_end    (m_packet_end),
        .m_packet_bad    (m_packet_bad),
        .m_run_last      (m_run_last)
    );

    // predictor state
    anbsc_pkg::window_t held_win;
    int unsigned        held_n = 0;
    int unsigned        skip_n = 0;
    bit                 at_head = 1'b1;
    bit                 bad_pkt = 1'b0;

    marked_byte_t pending_marks [$];
    marked_byte_t next_mark;

    int unsigned failures      = 0;
    int unsigned bytes_sent    = 0;
    int unsigned packets_sent  = 0;
    int unsigned results_seen  = 0;
    int unsigned random_bytes  = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;
    bit          steady        = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic append_mark(input marked_byte_t r);
        pending_marks.insert(pending_marks.size(), r);
    endtask

    // one scan position of the window: skip, prefix test, head and bad handling
    task automatic mark_position(input anbsc_pkg::window_t w, input int unsigned pos,
                                 input int unsigned avail, input bit pend, input bit last);
        logic [2:0]   pfx;
        marked_byte_t r;
        pfx = anbsc_pkg::PfxNone;
        if (skip_n != 0) begin
            skip_n = skip_n - 1;
        end else if (avail >= 3) begin
            if (avail >= 4 && w[pos] == anbsc_pkg::ZeroByte &&
                w[pos+1] == anbsc_pkg::ZeroByte &&
                w[pos+2] == anbsc_pkg::ZeroByte && w[pos+3] == anbsc_pkg::OneByte) begin
                pfx = anbsc_pkg::PfxLong;
            end else if (w[pos] == anbsc_pkg::ZeroByte && w[pos+1] == anbsc_pkg::ZeroByte &&
                         w[pos+2] == anbsc_pkg::OneByte) begin
                pfx = anbsc_pkg::PfxShort;
            end
            if (pfx != anbsc_pkg::PfxNone) begin
                skip_n = int'(pfx) - 1;
            end
        end
        if (at_head) begin
            if (pfx == anbsc_pkg::PfxNone) begin
                bad_pkt = 1'b1;
            end
            at_head = 1'b0;
        end
        if (bad_pkt) begin
            pfx = anbsc_pkg::PfxNone;
        end
        r.data = w[pos];
        r.nal  = (pfx != anbsc_pkg::PfxNone);
        r.plen = pfx;
        r.pend = pend;
        r.bad  = bad_pkt;
        r.last = last;
        append_mark(r);
    endtask

    task automatic split_byte(input logic [7:0] b, input bit eop);
        anbsc_pkg::window_t w;
        int unsigned        n;
        w = held_win;
        w[held_n] = b;
        n = held_n + 1;
        if (eop) begin
            for (int unsigned i = 0; i < n; i++) begin
                mark_position(w, i, n - i, i == n - 1, i == n - 1);
            end
            held_n  = 0;
            skip_n  = 0;
            at_head = 1'b1;
            bad_pkt = 1'b0;
        end else if (n == 4) begin
            mark_position(w, 0, 4, 1'b0, 1'b1);
            held_win[0] = w[1];
            held_win[1] = w[2];
            held_win[2] = w[3];
            held_n = 3;
        end else begin
            held_win = w;
            held_n   = n;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit eop);
        int unsigned gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 30) begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_byte_in       <= b;
        s_end_of_packet <= eop;
        do @(posedge aclk); while (!s_ready);
        split_byte(b, eop);
        bytes_sent++;
        if (eop) begin
            packets_sent++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_marks.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 4) begin
            return anbsc_pkg::ZeroByte;
        end else if (k < 6) begin
            return anbsc_pkg::OneByte;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // result side: check each transfer, then decide ready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_marks.size() == 0) begin
                $error("byte_out: expected nothing, got %0d", m_byte_out);
                failures++;
            end else begin
                next_mark = pending_marks.pop_front();
                compare_field("byte_out", next_mark.data, m_byte_out);
                compare_field("nal_start", 8'(next_mark.nal), 8'(m_nal_start));
                compare_field("prefix_length", 8'(next_mark.plen), 8'(m_prefix_length));
                compare_field("packet_end", 8'(next_mark.pend), 8'(m_packet_end));
                compare_field("packet_bad", 8'(next_mark.bad), 8'(m_packet_bad));
                compare_field("run_last", 8'(next_mark.last), 8'(m_run_last));
            end
            results_seen++;
        end
        if (!hold_done && results_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = 64;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 30);
        end
    end

    initial begin
        int unsigned kind;
        int unsigned pfx_len;
        int unsigned len;
        int unsigned guard;
        bit          drained_mid;
        logic [7:0]  b;

        drained_mid = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            send_byte(DIRECTED[i].data, DIRECTED[i].eop);
            // typed expectation stands in for the predicted one
            if (DIRECTED[i].typed) begin
                pending_marks[pending_marks.size() - 1] = DIRECTED[i].want;
            end
        end
        wait_drained();

        while (random_bytes < RandomBytes) begin
            steady = (random_bytes >= 80 && random_bytes < 150);
            if (!drained_mid && random_bytes >= 220) begin
                drained_mid = 1'b1;
                wait_drained();
            end
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                pfx_len = $urandom_range(3, 4);
                len     = pfx_len + $urandom_range(0, 8);
            end else if (kind == 7) begin
                pfx_len = 0;
                len     = $urandom_range(1, 2);
            end else begin
                pfx_len = 0;
                len     = $urandom_range(1, 10);
            end
            for (int unsigned i = 0; i < len; i++) begin
                if (i + 1 < pfx_len) begin
                    b = anbsc_pkg::ZeroByte;
                end else if (i + 1 == pfx_len) begin
                    b = anbsc_pkg::OneByte;
                end else begin
                    b = pick_byte();
                end
                send_byte(b, i == len - 1);
                random_bytes++;
            end
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        for (guard = 0; pending_marks.size() != 0 && guard < 20000; guard++) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (pending_marks.size() != 0) begin
            $error("byte_out: %0d results expected, none arrived", pending_marks.size());
            failures++;
        end

        $display("sent %0d bytes in %0d packets, %0d results checked", bytes_sent,
                 packets_sent, results_seen);
        $display("with idle gaps, a long receiver hold and sender drain pauses");
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+src
src/anbsc_pkg.sv
src/anbsc_queue.sv
src/anbsc_front.sv
src/anbsc_back.sv
src/annex_b_nal_start_code_splitter_unit.sv
src/anbsc_checker.sv
tb/testbench.sv
